// File: rtl/sprite_piece_place_clip_assert.svh
// ----------------------------------------------------------------------------
// Sprite piece place and clip - assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef SPRITE_PIECE_PLACE_CLIP_ASSERT_SVH
`define SPRITE_PIECE_PLACE_CLIP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check a property on every rising clock edge outside reset
`define SPPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sppc assertion failed");
// check a property on every rising clock edge, reset included
`define SPPC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sppc assertion failed");
`else
`define SPPC_ASSERT(lbl, clk, rst_n, prop)
`define SPPC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/sppc_pkg.sv
// ----------------------------------------------------------------------------
// Sprite piece place and clip - package
// Payload types, configuration layout and codes shared by the block.
// ----------------------------------------------------------------------------
package sppc_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned SlotW    = 7;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_CLIP_TOP    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_CLIP_BOTTOM = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_CLIP_LEFT   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_CLIP_RIGHT  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SLOT_LIMIT  = 3'd4;

    // opcodes
    localparam logic OP_FRAME_START = 1'b0;
    localparam logic OP_PIECE       = 1'b1;

    // reset values
    localparam logic signed [15:0] CLIP_TOP_RST    = 16'sd128;
    localparam logic signed [15:0] CLIP_BOTTOM_RST = 16'sd384;
    localparam logic signed [15:0] CLIP_LEFT_RST   = 16'sd128;
    localparam logic signed [15:0] CLIP_RIGHT_RST  = 16'sd448;
    localparam logic [SlotW-1:0]   SLOT_LIMIT_RST  = 7'd80;

    localparam logic [15:0]      X_BIAS   = 16'd32;
    localparam logic [SlotW-1:0] SLOT_MAX = 7'd127;

    typedef struct packed {
        logic              opcode;
        logic              first_of_object;
        logic signed [15:0] object_x;
        logic signed [15:0] object_y;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic [8:0]        piece_width;
        logic [8:0]        piece_height;
        logic [9:0]        bitmap_index;
        logic [1:0]        flip_mode;
    } t_piece;

    typedef struct packed {
        logic signed [15:0] sprite_x;
        logic signed [15:0] sprite_y;
        logic [9:0]        sprite_bitmap;
        logic [SlotW-1:0]  link_slot;
        logic [1:0]        sprite_flip;
    } t_sprite;

    typedef struct packed {
        logic signed [15:0] clip_top;
        logic signed [15:0] clip_bottom;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_right;
        logic [SlotW-1:0]  slot_limit;
    } t_cfg;

    // placed position and clip verdict of one piece
    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        visible;
    } t_place;

endpackage

// File: rtl/sppc_stream_if.sv
// ----------------------------------------------------------------------------
// Sprite piece place and clip - stream channel
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface sppc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/sppc_cfg.sv
// ----------------------------------------------------------------------------
// Sprite piece place and clip - configuration registers
// Clip window and slot limit, written through a plain write port.
// ----------------------------------------------------------------------------
module sppc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sppc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [sppc_pkg::CfgDataW-1:0] i_cfg_data,
    output sppc_pkg::t_cfg                o_cfg
);

    sppc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_top    <= sppc_pkg::CLIP_TOP_RST;
            r_cfg.clip_bottom <= sppc_pkg::CLIP_BOTTOM_RST;
            r_cfg.clip_left   <= sppc_pkg::CLIP_LEFT_RST;
            r_cfg.clip_right  <= sppc_pkg::CLIP_RIGHT_RST;
            r_cfg.slot_limit  <= sppc_pkg::SLOT_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sppc_pkg::CFG_CLIP_TOP:    r_cfg.clip_top    <= i_cfg_data;
                sppc_pkg::CFG_CLIP_BOTTOM: r_cfg.clip_bottom <= i_cfg_data;
                sppc_pkg::CFG_CLIP_LEFT:   r_cfg.clip_left   <= i_cfg_data;
                sppc_pkg::CFG_CLIP_RIGHT:  r_cfg.clip_right  <= i_cfg_data;
                sppc_pkg::CFG_SLOT_LIMIT:
                    r_cfg.slot_limit <= i_cfg_data[sppc_pkg::SlotW-1:0];
                default: ;  // unknown index: ignore
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/sppc_place.sv
// ----------------------------------------------------------------------------
// Sprite piece place and clip - placement datapath
// Scales and biases the object x, applies flips and tests the clip window.
// ----------------------------------------------------------------------------
module sppc_place (
    input  sppc_pkg::t_piece i_piece,
    input  sppc_pkg::t_cfg   i_cfg,
    output sppc_pkg::t_place o_place
);

    logic signed [18:0] x5;
    logic signed [18:0] x5_adj;
    logic signed [18:0] x_q;
    logic [15:0]        base_x;
    logic [15:0]        w16;
    logic [15:0]        h16;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [17:0] right_edge;
    logic signed [17:0] bottom_edge;
    logic signed [17:0] clip_l;
    logic signed [17:0] clip_t;

    always_comb begin
        // x * 5, then divide by 4 rounding toward zero
        x5     = {{3{i_piece.object_x[15]}}, i_piece.object_x}
               + {i_piece.object_x[15], i_piece.object_x, 2'b00};
        x5_adj = x5 + (x5[18] ? 19'sd3 : 19'sd0);
        x_q    = x5_adj >>> 2;
        base_x = x_q[15:0] - sppc_pkg::X_BIAS;

        w16 = {7'd0, i_piece.piece_width};
        h16 = {7'd0, i_piece.piece_height};

        // mirror about the piece size when flipped
        pos_x = i_piece.flip_mode[0] ? (base_x - i_piece.offset_x - w16)
                                     : (base_x + i_piece.offset_x);
        pos_y = i_piece.flip_mode[1] ? (i_piece.object_y - i_piece.offset_y - h16)
                                     : (i_piece.object_y + i_piece.offset_y);

        // edges compared without wrapping
        right_edge  = {{2{pos_x[15]}}, pos_x} + {9'd0, i_piece.piece_width};
        bottom_edge = {{2{pos_y[15]}}, pos_y} + {9'd0, i_piece.piece_height};
        clip_l      = {{2{i_cfg.clip_left[15]}}, i_cfg.clip_left};
        clip_t      = {{2{i_cfg.clip_top[15]}}, i_cfg.clip_top};

        o_place.pos_x   = pos_x;
        o_place.pos_y   = pos_y;
        o_place.visible = (bottom_edge > clip_t)
                       && ($signed(pos_y) < i_cfg.clip_bottom)
                       && (right_edge > clip_l)
                       && ($signed(pos_x) < i_cfg.clip_right);
    end

endmodule

// File: rtl/sprite_piece_place_clip.sv
// ----------------------------------------------------------------------------
// Sprite piece place and clip - top level
// Places sprite pieces on screen, clips them and hands out link slots.
// ----------------------------------------------------------------------------
// Usage:
//   i_piece carries one item per sprite piece or frame start (valid/ready).
//   o_sprite returns one item for each visible piece that gets a link slot;
//   frame starts, dropped objects and clipped pieces give no item.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while the block is idle.
// Pipeline: an accepted item is held in the input register; its result is
//   shown from the output register on o_sprite.
// Throughput: one item per cycle unless o_sprite is held off; the slot
//   counter is updated in the same cycle the item leaves the input register,
//   so pieces follow back to back.
// Reset: synchronous, active low; both stages empty, slot count and drop
//   flag cleared, clip window back to 128..448 by 128..384, slot limit 80.
// Stall: while o_sprite is held off, the output register keeps its item and
//   the input register fills once more; then i_piece.ready drops.
// ----------------------------------------------------------------------------
`include "sprite_piece_place_clip_assert.svh"

module sprite_piece_place_clip (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sppc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [sppc_pkg::CfgDataW-1:0] i_cfg_data,
    sppc_stream_if.sink                   i_piece,
    sppc_stream_if.source                 o_sprite
);

    sppc_pkg::t_cfg   cfg;
    sppc_pkg::t_place place;

    logic                       r_in_valid;
    sppc_pkg::t_piece           r_in;
    logic                       r_out_valid;
    sppc_pkg::t_sprite          r_out;
    logic [sppc_pkg::SlotW-1:0] r_slot_count;
    logic                       r_dropping;

    logic                       advance;
    logic                       drop_now;
    logic                       emit;
    logic [sppc_pkg::SlotW-1:0] n_slot_count;
    logic                       n_dropping;

    sppc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sppc_place u_place (
        .i_piece (r_in),
        .i_cfg   (cfg),
        .o_place (place)
    );

    assign advance       = r_in_valid && (!r_out_valid || o_sprite.ready);
    assign i_piece.ready = !r_in_valid || advance;

    always_comb begin
        drop_now = r_in.first_of_object ? (r_slot_count >= cfg.slot_limit)
                                        : r_dropping;
        emit = (r_in.opcode == sppc_pkg::OP_PIECE) && !drop_now
            && place.visible && (r_slot_count != sppc_pkg::SLOT_MAX);

        n_slot_count = r_slot_count;
        n_dropping   = r_dropping;
        if (r_in.opcode == sppc_pkg::OP_FRAME_START) begin
            n_slot_count = '0;
            n_dropping   = 1'b0;
        end else begin
            n_dropping = drop_now;
            if (emit) begin
                n_slot_count = r_slot_count + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_slot_count <= '0;
            r_dropping   <= 1'b0;
        end else begin
            if (i_piece.valid && i_piece.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid  <= emit;
                r_slot_count <= n_slot_count;
                r_dropping   <= n_dropping;
            end else if (o_sprite.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: hold unless loaded
    always_ff @(posedge i_clk) begin
        if (i_piece.valid && i_piece.ready) begin
            r_in <= i_piece.payload;
        end
        if (advance && emit) begin
            r_out.sprite_x      <= place.pos_x;
            r_out.sprite_y      <= place.pos_y;
            r_out.sprite_bitmap <= r_in.bitmap_index;
            r_out.link_slot     <= r_slot_count;
            r_out.sprite_flip   <= r_in.flip_mode;
        end
    end

    assign o_sprite.valid   = r_out_valid;
    assign o_sprite.payload = r_out;

    `SPPC_ASSERT(a_slot_advance, i_clk, i_rst_n, (advance && emit) |=> (r_slot_count == ($past(r_slot_count) + 7'd1)))
    `SPPC_ASSERT(a_frame_clear, i_clk, i_rst_n, (advance && (r_in.opcode == sppc_pkg::OP_FRAME_START)) |=> ((r_slot_count == 7'd0) && !r_dropping))
    `SPPC_ASSERT(a_slot_in_range, i_clk, i_rst_n, r_out_valid |-> (r_out.link_slot != sppc_pkg::SLOT_MAX))
    `SPPC_ASSERT(a_hold_on_stall, i_clk, i_rst_n, (r_in_valid && r_out_valid && !o_sprite.ready) |=> (r_in_valid && r_out_valid))

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Sprite piece place and clip - testbench
// Drives pieces and frame starts through the valid/ready channels, predicts
// placement, clipping and link slots, and checks every sprite against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    typedef enum {ROW_PREDICT, ROW_SILENT, ROW_SHOWN, ROW_SET} t_row_kind;

    typedef struct {
        t_row_kind                    kind;
        sppc_pkg::t_piece             item;
        sppc_pkg::t_sprite            shown;
        logic [sppc_pkg::CfgIdxW-1:0] reg_idx;
        logic [15:0]                  reg_val;
    } t_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [sppc_pkg::CfgIdxW-1:0]  i_cfg_index;
    logic [sppc_pkg::CfgDataW-1:0] i_cfg_data;

    sppc_stream_if #(.T(sppc_pkg::t_piece))  piece_if ();
    sppc_stream_if #(.T(sppc_pkg::t_sprite)) sprite_if ();

    sprite_piece_place_clip u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_piece     (piece_if),
        .o_sprite    (sprite_if)
    );

    // predictor copy of the window and the link counter
    int win_top    = int'(sppc_pkg::CLIP_TOP_RST);
    int win_bottom = int'(sppc_pkg::CLIP_BOTTOM_RST);
    int win_left   = int'(sppc_pkg::CLIP_LEFT_RST);
    int win_right  = int'(sppc_pkg::CLIP_RIGHT_RST);
    int link_cap   = int'(sppc_pkg::SLOT_LIMIT_RST);
    int links_used = 0;
    bit skip_object = 1'b0;

    sppc_pkg::t_sprite placed_q[$];
    t_row              dir_rows[$];
    int                mismatches = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #1000000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic int to_s16(input int v);
        logic signed [15:0] t;
        t = v[15:0];
        return int'(t);
    endfunction

    // place and clip one item, advance the link counter; 1 when a sprite comes out
    function automatic bit place_piece(input sppc_pkg::t_piece p,
                                       output sppc_pkg::t_sprite s);
        int ox, oy, dx, dy, w, h, base_x, pos_x, pos_y;
        s = '0;
        if (p.opcode == sppc_pkg::OP_FRAME_START) begin
            links_used  = 0;
            skip_object = 1'b0;
            return 1'b0;
        end
        if (p.first_of_object)
            skip_object = (links_used >= link_cap);
        if (skip_object)
            return 1'b0;
        ox = int'(p.object_x);
        oy = int'(p.object_y);
        dx = int'(p.offset_x);
        dy = int'(p.offset_y);
        w  = int'(p.piece_width);
        h  = int'(p.piece_height);
        base_x = to_s16(ox * 5 / 4 - int'(sppc_pkg::X_BIAS));
        pos_x = p.flip_mode[0] ? to_s16(base_x - dx - w) : to_s16(base_x + dx);
        pos_y = p.flip_mode[1] ? to_s16(oy - dy - h) : to_s16(oy + dy);
        // edge sums at full width, no wrap
        if (!(pos_y + h > win_top && pos_y < win_bottom &&
              pos_x + w > win_left && pos_x < win_right))
            return 1'b0;
        if (links_used >= int'(sppc_pkg::SLOT_MAX))
            return 1'b0;
        s.sprite_x      = pos_x[15:0];
        s.sprite_y      = pos_y[15:0];
        s.sprite_bitmap = p.bitmap_index;
        s.link_slot     = links_used[sppc_pkg::SlotW-1:0];
        s.sprite_flip   = p.flip_mode;
        links_used++;
        return 1'b1;
    endfunction

    function automatic void cmp_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_sprite(input sppc_pkg::t_sprite got);
        sppc_pkg::t_sprite want;
        if (placed_q.size() == 0) begin
            $display("%0t: sprite with none expected, got %h", $time, got);
            mismatches++;
            return;
        end
        want = placed_q.pop_front();
        cmp_field("sprite_x", want.sprite_x, got.sprite_x);
        cmp_field("sprite_y", want.sprite_y, got.sprite_y);
        cmp_field("sprite_bitmap", 16'(want.sprite_bitmap), 16'(got.sprite_bitmap));
        cmp_field("link_slot", 16'(want.link_slot), 16'(got.link_slot));
        cmp_field("sprite_flip", 16'(want.sprite_flip), 16'(got.sprite_flip));
    endfunction

    function automatic sppc_pkg::t_piece mk_piece(input logic op, input int first,
                                                  input int ox, input int oy,
                                                  input int dx, input int dy,
                                                  input int w, input int h,
                                                  input int bmp, input int flip);
        sppc_pkg::t_piece p;
        p.opcode          = op;
        p.first_of_object = 1'(first);
        p.object_x        = 16'(ox);
        p.object_y        = 16'(oy);
        p.offset_x        = 16'(dx);
        p.offset_y        = 16'(dy);
        p.piece_width     = 9'(w);
        p.piece_height    = 9'(h);
        p.bitmap_index    = 10'(bmp);
        p.flip_mode       = 2'(flip);
        return p;
    endfunction

    function automatic sppc_pkg::t_sprite mk_sprite(input int x, input int y,
                                                    input int bmp, input int slot,
                                                    input int flip);
        sppc_pkg::t_sprite s;
        s.sprite_x      = 16'(x);
        s.sprite_y      = 16'(y);
        s.sprite_bitmap = 10'(bmp);
        s.link_slot     = sppc_pkg::SlotW'(slot);
        s.sprite_flip   = 2'(flip);
        return s;
    endfunction

    function automatic void add_row(input t_row_kind kind, input sppc_pkg::t_piece p,
                                    input sppc_pkg::t_sprite s);
        t_row r;
        r.kind    = kind;
        r.item    = p;
        r.shown   = s;
        r.reg_idx = '0;
        r.reg_val = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_set(input logic [sppc_pkg::CfgIdxW-1:0] idx,
                                    input int val);
        t_row r;
        r.kind    = ROW_SET;
        r.item    = '0;
        r.shown   = '0;
        r.reg_idx = idx;
        r.reg_val = 16'(val);
        dir_rows.push_back(r);
    endfunction

    function automatic logic [15:0] near16(input int lo, input int hi);
        int v;
        v = lo + int'($urandom_range(hi - lo));
        return v[15:0];
    endfunction

    // output side: check what comes out, stall at random or hold off on request
    initial begin : sprite_sink
        sprite_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && sprite_if.valid && sprite_if.ready)
                check_sprite(sprite_if.payload);
            if (hold_left > 0) begin
                sprite_if.ready <= 1'b0;
                hold_left--;
            end else begin
                sprite_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic offer_piece(input sppc_pkg::t_piece p);
        while ($urandom_range(99) < send_idle_pct) begin
            piece_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        piece_if.valid   <= 1'b1;
        piece_if.payload <= p;
        do @(posedge i_clk); while (!piece_if.ready);
    endtask

    task automatic issue_piece(input sppc_pkg::t_piece p);
        sppc_pkg::t_sprite s;
        offer_piece(p);
        if (place_piece(p, s))
            placed_q.push_back(s);
    endtask

    // drop valid, wait for every sprite, then let clipped items clear the pipe
    task automatic settle();
        piece_if.valid <= 1'b0;
        while (placed_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [sppc_pkg::CfgIdxW-1:0] idx,
                           input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        unique case (idx)
            sppc_pkg::CFG_CLIP_TOP:    win_top    = int'($signed(val));
            sppc_pkg::CFG_CLIP_BOTTOM: win_bottom = int'($signed(val));
            sppc_pkg::CFG_CLIP_LEFT:   win_left   = int'($signed(val));
            sppc_pkg::CFG_CLIP_RIGHT:  win_right  = int'($signed(val));
            sppc_pkg::CFG_SLOT_LIMIT:  link_cap   = int'(val[sppc_pkg::SlotW-1:0]);
            default: ;
        endcase
    endtask

    task automatic run_phase(input int top, input int bottom, input int left,
                             input int right, input int limit,
                             input int idle, input int stall, input int n_items,
                             input int frame_pct, input int noise_pct,
                             input int hold);
        sppc_pkg::t_piece p;
        logic [15:0]      lim_word;
        int               sent, pick, pieces;
        bit               wide;
        settle();
        set_reg(sppc_pkg::CFG_CLIP_TOP, 16'(top));
        set_reg(sppc_pkg::CFG_CLIP_BOTTOM, 16'(bottom));
        set_reg(sppc_pkg::CFG_CLIP_LEFT, 16'(left));
        set_reg(sppc_pkg::CFG_CLIP_RIGHT, 16'(right));
        // junk above the limit field must be ignored
        lim_word = 16'($urandom);
        lim_word[sppc_pkg::SlotW-1:0] = sppc_pkg::SlotW'(limit);
        set_reg(sppc_pkg::CFG_SLOT_LIMIT, lim_word);
        for (int i = sppc_pkg::CFG_SLOT_LIMIT + 1; i < (1 << sppc_pkg::CfgIdxW); i++)
            set_reg(sppc_pkg::CfgIdxW'(i), 16'($urandom));
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        hold_left      = hold;
        issue_piece(mk_piece(sppc_pkg::OP_FRAME_START, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        sent = 1;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < noise_pct) begin
                p = {$urandom, $urandom, $urandom};
                issue_piece(p);
                sent++;
            end else if (pick < noise_pct + frame_pct) begin
                p = {$urandom, $urandom, $urandom};
                p.opcode = sppc_pkg::OP_FRAME_START;
                issue_piece(p);
                sent++;
            end else begin
                p.opcode          = sppc_pkg::OP_PIECE;
                p.first_of_object = 1'b1;
                if ($urandom_range(99) < 85) begin
                    p.object_x = near16(0, 400);
                    p.object_y = near16(-40, 460);
                end else begin
                    p.object_x = 16'($urandom);
                    p.object_y = 16'($urandom);
                end
                pieces = $urandom_range(1, 6);
                for (int k = 0; k < pieces; k++) begin
                    wide = ($urandom_range(9) == 0);
                    p.offset_x     = wide ? 16'($urandom) : near16(-80, 80);
                    p.offset_y     = wide ? 16'($urandom) : near16(-80, 80);
                    p.piece_width  = wide ? 9'($urandom) : 9'($urandom_range(80));
                    p.piece_height = wide ? 9'($urandom) : 9'($urandom_range(80));
                    p.bitmap_index = 10'($urandom);
                    p.flip_mode    = 2'($urandom);
                    issue_piece(p);
                    p.first_of_object = 1'b0;
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        sppc_pkg::t_sprite spare;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_data       <= '0;
        piece_if.valid   <= 1'b0;
        piece_if.payload <= '0;

        // reset window 128..448 by 128..384, slot limit 80
        add_row(ROW_SILENT,
                mk_piece(sppc_pkg::OP_FRAME_START, 0, 0, 0, 0, 0, 0, 0, 0, 0), '0);
        add_row(ROW_SHOWN, mk_piece(sppc_pkg::OP_PIECE, 1, 128, 200, 0, 0, 16, 16, 5, 0),
                mk_sprite(128, 200, 5, 0, 0));
        add_row(ROW_SHOWN,
                mk_piece(sppc_pkg::OP_PIECE, 0, 128, 200, -40, 0, 16, 16, 1023, 1),
                mk_sprite(152, 200, 1023, 1, 1));
        add_row(ROW_SHOWN, mk_piece(sppc_pkg::OP_PIECE, 0, 128, 200, 0, 10, 16, 20, 0, 2),
                mk_sprite(128, 170, 0, 2, 2));
        add_row(ROW_SHOWN,
                mk_piece(sppc_pkg::OP_PIECE, 0, 128, 200, -40, 10, 16, 20, 512, 3),
                mk_sprite(152, 170, 512, 3, 3));
        add_row(ROW_SILENT,
                mk_piece(sppc_pkg::OP_PIECE, 1, 0, 200, 0, 0, 0, 16, 6, 0), '0);
        // each window edge just outside, and top, bottom and right just inside
        add_row(ROW_SILENT,
                mk_piece(sppc_pkg::OP_PIECE, 0, 128, 100, 0, 0, 16, 28, 7, 0), '0);
        add_row(ROW_SHOWN, mk_piece(sppc_pkg::OP_PIECE, 0, 128, 100, 0, 0, 16, 29, 7, 0),
                mk_sprite(128, 100, 7, 4, 0));
        add_row(ROW_SILENT,
                mk_piece(sppc_pkg::OP_PIECE, 0, 128, 384, 0, 0, 16, 16, 8, 0), '0);
        add_row(ROW_SHOWN, mk_piece(sppc_pkg::OP_PIECE, 0, 128, 383, 0, 0, 16, 1, 8, 0),
                mk_sprite(128, 383, 8, 5, 0));
        add_row(ROW_SILENT,
                mk_piece(sppc_pkg::OP_PIECE, 0, 128, 200, 320, 0, 16, 16, 9, 0), '0);
        add_row(ROW_SHOWN, mk_piece(sppc_pkg::OP_PIECE, 0, 128, 200, 319, 0, 1, 1, 9, 0),
                mk_sprite(447, 200, 9, 6, 0));
        add_row(ROW_SILENT,
                mk_piece(sppc_pkg::OP_PIECE, 0, 128, 200, -16, 0, 16, 16, 10, 0), '0);
        // field extremes and a negative odd x for the truncating scale
        add_row(ROW_PREDICT, mk_piece(sppc_pkg::OP_PIECE, 1, 32767, -32768, 32767, 32767,
                                      511, 511, 1023, 3), '0);
        add_row(ROW_PREDICT, mk_piece(sppc_pkg::OP_PIECE, 1, -32768, 32767, -32768,
                                      -32768, 511, 511, 0, 0), '0);
        add_row(ROW_PREDICT,
                mk_piece(sppc_pkg::OP_PIECE, 1, -3, 200, 200, 0, 16, 16, 3, 0), '0);
        // bottom edge past the 16-bit range still counts as below the top
        add_set(sppc_pkg::CFG_CLIP_TOP, 32767);
        add_set(sppc_pkg::CFG_CLIP_BOTTOM, 32767);
        add_row(ROW_PREDICT,
                mk_piece(sppc_pkg::OP_PIECE, 0, 128, 32700, 0, 0, 16, 200, 4, 0), '0);
        add_set(sppc_pkg::CFG_CLIP_TOP, 128);
        add_set(sppc_pkg::CFG_CLIP_BOTTOM, 384);
        // object drop at the slot limit, cleared by frame start
        add_set(sppc_pkg::CFG_SLOT_LIMIT, 2);
        add_row(ROW_SILENT,
                mk_piece(sppc_pkg::OP_FRAME_START, 0, 0, 0, 0, 0, 0, 0, 0, 0), '0);
        add_row(ROW_SHOWN, mk_piece(sppc_pkg::OP_PIECE, 1, 128, 200, 0, 0, 16, 16, 11, 0),
                mk_sprite(128, 200, 11, 0, 0));
        add_row(ROW_SHOWN, mk_piece(sppc_pkg::OP_PIECE, 0, 128, 200, 0, 0, 16, 16, 12, 0),
                mk_sprite(128, 200, 12, 1, 0));
        add_row(ROW_SILENT,
                mk_piece(sppc_pkg::OP_PIECE, 1, 128, 200, 0, 0, 16, 16, 13, 0), '0);
        add_row(ROW_SILENT,
                mk_piece(sppc_pkg::OP_PIECE, 0, 128, 200, 0, 0, 16, 16, 13, 0), '0);
        add_row(ROW_SILENT,
                mk_piece(sppc_pkg::OP_FRAME_START, 0, 0, 0, 0, 0, 0, 0, 0, 0), '0);
        add_row(ROW_SHOWN, mk_piece(sppc_pkg::OP_PIECE, 0, 128, 200, 0, 0, 16, 16, 14, 0),
                mk_sprite(128, 200, 14, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            unique case (dir_rows[i].kind)
                ROW_SET: begin
                    settle();
                    set_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
                end
                ROW_PREDICT: issue_piece(dir_rows[i].item);
                default: begin
                    offer_piece(dir_rows[i].item);
                    void'(place_piece(dir_rows[i].item, spare));
                    if (dir_rows[i].kind == ROW_SHOWN)
                        placed_q.push_back(dir_rows[i].shown);
                end
            endcase
        end

        run_phase(128, 384, 128, 448, 80, 0, 0, 250, 3, 8, 0);
        run_phase(0, 240, 0, 320, 40, 79, 0, 250, 3, 8, 0);
        // open window, no frame starts after the first: count runs into saturation;
        // long hold-off fills the pipe and stalls the input
        run_phase(-32768, 32767, -32768, 32767, 127, 0, 79, 250, 0, 0, 400);
        run_phase(200, 201, 300, 301, 1, 34, 34, 200, 3, 8, 0);
        run_phase(32767, -32768, 32767, -32768, 0, 0, 0, 100, 3, 8, 0);
        run_phase($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                  $urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                  $urandom_range(127), 79, 0, 200, 3, 8, 0);
        run_phase(128, 384, 128, 448, 127, 0, 79, 250, 2, 8, 0);
        run_phase(-100, 500, -200, 600, 20, 34, 34, 200, 3, 8, 0);

        settle();
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/sppc_pkg.sv
rtl/sppc_stream_if.sv
rtl/sppc_cfg.sv
rtl/sppc_place.sv
rtl/sprite_piece_place_clip.sv
test/testbench.sv
